>>> rtl/i2c_eeprom_byte_master_core_macros.svh
// assertion macros for the i2c eeprom byte master core
// used only by the top level, no other dependencies
`ifndef I2C_EEPROM_BYTE_MASTER_CORE_MACROS_SVH
`define I2C_EEPROM_BYTE_MASTER_CORE_MACROS_SVH

// same-cycle implication
`define I2CEBM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("i2cebm assertion failed");

// next-cycle implication
`define I2CEBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("i2cebm assertion failed");

`endif

>>> rtl/i2cebm_pkg.sv
// shared types, constants and the step table of the i2c eeprom byte master
// no dependencies
`default_nettype none

package i2cebm_pkg;

	localparam int unsigned STEP_W = 5;
	localparam logic [STEP_W-1:0] STEP_IDLE        = 5'd0;
	localparam logic [STEP_W-1:0] STEP_WRITE_FIRST = 5'd1;
	localparam logic [STEP_W-1:0] STEP_WRITE_WAIT  = 5'd9;
	localparam logic [STEP_W-1:0] STEP_READ_FIRST  = 5'd10;
	localparam logic [STEP_W-1:0] STEP_READ_WAIT   = 5'd20;
	localparam logic [STEP_W-1:0] STEP_COUNT       = 5'd21;

	localparam logic [1:0] ACTION_TICK  = 2'd0;
	localparam logic [1:0] ACTION_WRITE = 2'd1;
	localparam logic [1:0] ACTION_READ  = 2'd2;

	localparam logic [1:0] REG_WRITE_WAIT  = 2'd0;
	localparam logic [1:0] REG_READ_WAIT   = 2'd1;
	localparam logic [1:0] REG_ACK_TIMEOUT = 2'd2;

	localparam logic [15:0] WRITE_WAIT_RESET  = 16'd5000;
	localparam logic [15:0] READ_WAIT_RESET   = 16'd100;
	localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd255;

	localparam logic [7:0] DEV_ADDR_WRITE = 8'hA0;
	localparam logic [7:0] DEV_ADDR_READ  = 8'hA1;
	localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_START,
		OP_WA0,
		OP_WADDR,
		OP_WDATA,
		OP_WA1,
		OP_ACK,
		OP_RBYTE,
		OP_STOP,
		OP_WAIT
	} op_t;

	typedef struct packed {
		logic [15:0] write_wait;
		logic [15:0] read_wait;
		logic [7:0]  ack_timeout;
	} cfg_t;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic [1:0]        phase;
		logic [3:0]        bit_cnt;
		logic [7:0]        shift;
		logic              is_read;
		logic [7:0]        held_addr;
		logic [7:0]        held_data;
		logic [15:0]       wait_cnt;
		logic [7:0]        rx_byte;
		logic              scl;
		logic              sda;
	} seq_t;

	function automatic op_t step_op(input logic [STEP_W-1:0] step);
		op_t op;
		unique case (step)
			5'd1, 5'd10, 5'd15:        op = OP_START;
			5'd2, 5'd11:               op = OP_WA0;
			5'd3, 5'd5, 5'd7, 5'd12,
			5'd14, 5'd17:              op = OP_ACK;
			5'd4, 5'd13:               op = OP_WADDR;
			5'd6:                      op = OP_WDATA;
			5'd16:                     op = OP_WA1;
			5'd18:                     op = OP_RBYTE;
			5'd8, 5'd19:               op = OP_STOP;
			5'd9, 5'd20:               op = OP_WAIT;
			default:                   op = OP_IDLE;
		endcase
		return op;
	endfunction

endpackage

`default_nettype wire

>>> rtl/i2c_eeprom_byte_master_core.sv
// top level of the tick-driven i2c master for a 24c02 eeprom
// depends on i2cebm_pkg, i2cebm_cfg, i2cebm_step and the macros header
//
// Usage: every input word is one bus-phase tick (usually from a prescaler).
// The action field starts a byte write or a random read when the sequencer
// is idle; actions during a running command are ignored. Each accepted tick
// yields exactly one output word with the scl level, the sda release level,
// busy, done and the last byte read.
// Output: the output word for a tick is registered and valid in the cycle after
// the tick is accepted. Throughput: one tick per clock cycle while out_ready is
// high, set by the single register stage around the sequencer next-state logic.
// Stall: when out_ready is low the output register holds its word and
// in_ready drops until the word is taken; no tick is lost or repeated.
// Reset: arst_n clears the sequencer to idle with both bus lines released
// high and loads the wait and timeout registers with their defaults.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are meant to be done while no command runs.
`default_nettype none

module i2c_eeprom_byte_master_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  mem_address,
	input  wire logic [7:0]  write_data,
	input  wire logic        sda_level,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             clock_line,
	output logic             data_release,
	output logic             busy_res,
	output logic             done_res,
	output logic [7:0]       read_byte
);

	`include "i2c_eeprom_byte_master_core_macros.svh"

	i2cebm_pkg::cfg_t cfg;
	i2cebm_pkg::seq_t seq_q;
	i2cebm_pkg::seq_t seq_nxt;
	logic             busy_c;
	logic             done_c;
	logic             accept;
	logic             out_valid_q;

	i2cebm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	i2cebm_step u_step (
		.cur         (seq_q),
		.cfg         (cfg),
		.action      (action),
		.mem_address (mem_address),
		.write_data  (write_data),
		.sda_level   (sda_level),
		.nxt         (seq_nxt),
		.busy        (busy_c),
		.done        (done_c)
	);

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '{step: i2cebm_pkg::STEP_IDLE, scl: 1'b1, sda: 1'b1, default: '0};
		end else if (accept) begin
			seq_q <= seq_nxt;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			clock_line   <= seq_nxt.scl;
			data_release <= seq_nxt.sda;
			busy_res     <= busy_c;
			done_res     <= done_c;
			read_byte    <= seq_nxt.rx_byte;
		end
	end

	assign out_valid = out_valid_q;

	`I2CEBM_ASSERT_NOW(a_done_only_in_wait, clk, arst_n, accept && done_c,
		seq_q.step == i2cebm_pkg::STEP_WRITE_WAIT || seq_q.step == i2cebm_pkg::STEP_READ_WAIT)
	`I2CEBM_ASSERT_NEXT(a_accept_gives_word, clk, arst_n, accept, out_valid)
	`I2CEBM_ASSERT_NEXT(a_idle_tick_not_busy, clk, arst_n,
		accept && seq_q.step == i2cebm_pkg::STEP_IDLE && action == i2cebm_pkg::ACTION_TICK,
		!busy_res && !done_res)
	`I2CEBM_ASSERT_NOW(a_done_not_busy, clk, arst_n, out_valid, !(busy_res && done_res))

endmodule

`default_nettype wire

>>> rtl/i2cebm_cfg.sv
// configuration registers: wait lengths and acknowledge timeout
// depends on i2cebm_pkg
`default_nettype none

module i2cebm_cfg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data,
	output i2cebm_pkg::cfg_t       cfg
);

	i2cebm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.write_wait  <= i2cebm_pkg::WRITE_WAIT_RESET;
			cfg_q.read_wait   <= i2cebm_pkg::READ_WAIT_RESET;
			cfg_q.ack_timeout <= i2cebm_pkg::ACK_TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				i2cebm_pkg::REG_WRITE_WAIT:  cfg_q.write_wait  <= cfg_data;
				i2cebm_pkg::REG_READ_WAIT:   cfg_q.read_wait   <= cfg_data;
				i2cebm_pkg::REG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/i2cebm_step.sv
// next-state logic of the bus sequencer for one tick
// depends on i2cebm_pkg
`default_nettype none

module i2cebm_step (
	input  wire i2cebm_pkg::seq_t  cur,
	input  wire i2cebm_pkg::cfg_t  cfg,
	input  wire logic [1:0]        action,
	input  wire logic [7:0]        mem_address,
	input  wire logic [7:0]        write_data,
	input  wire logic              sda_level,
	output i2cebm_pkg::seq_t       nxt,
	output logic                   busy,
	output logic                   done
);

	i2cebm_pkg::op_t op;
	logic [7:0]      tx_byte;

	always_comb begin
		nxt  = cur;
		busy = 1'b0;
		done = 1'b0;

		// out-of-range step behaves as idle
		if (cur.step >= i2cebm_pkg::STEP_COUNT) begin
			nxt.step = i2cebm_pkg::STEP_IDLE;
		end

		if (nxt.step == i2cebm_pkg::STEP_IDLE &&
		    (action == i2cebm_pkg::ACTION_WRITE || action == i2cebm_pkg::ACTION_READ)) begin
			nxt.held_addr = mem_address;
			if (action == i2cebm_pkg::ACTION_WRITE) begin
				nxt.held_data = write_data;
				nxt.is_read   = 1'b0;
				nxt.step      = i2cebm_pkg::STEP_WRITE_FIRST;
			end else begin
				nxt.is_read   = 1'b1;
				nxt.step      = i2cebm_pkg::STEP_READ_FIRST;
			end
			nxt.phase   = 2'd0;
			nxt.bit_cnt = 4'd0;
		end

		op   = i2cebm_pkg::step_op(nxt.step);
		busy = (op != i2cebm_pkg::OP_IDLE);

		unique case (op)
			i2cebm_pkg::OP_WA0:   tx_byte = i2cebm_pkg::DEV_ADDR_WRITE;
			i2cebm_pkg::OP_WA1:   tx_byte = i2cebm_pkg::DEV_ADDR_READ;
			i2cebm_pkg::OP_WADDR: tx_byte = nxt.held_addr;
			default:              tx_byte = nxt.held_data;
		endcase

		unique case (op)
			i2cebm_pkg::OP_START: begin
				unique case (nxt.phase)
					2'd0:    nxt.sda = 1'b1;
					2'd1:    nxt.scl = 1'b1;
					2'd2:    nxt.sda = 1'b0;
					default: nxt.scl = 1'b0;
				endcase
				if (nxt.phase == 2'd3) begin
					nxt.step    = nxt.step + 1'b1;
					nxt.phase   = 2'd0;
					nxt.bit_cnt = 4'd0;
				end else begin
					nxt.phase = nxt.phase + 1'b1;
				end
			end
			i2cebm_pkg::OP_WA0, i2cebm_pkg::OP_WADDR,
			i2cebm_pkg::OP_WDATA, i2cebm_pkg::OP_WA1: begin
				if (nxt.bit_cnt < i2cebm_pkg::BITS_PER_BYTE) begin
					if (nxt.phase == 2'd0) begin
						if (nxt.bit_cnt == 4'd0) begin
							nxt.shift = tx_byte;
						end
						nxt.scl   = 1'b0;
						nxt.phase = 2'd1;
					end else if (nxt.phase == 2'd1) begin
						nxt.sda   = nxt.shift[7];
						nxt.shift = {nxt.shift[6:0], 1'b0};
						nxt.phase = 2'd2;
					end else begin
						nxt.scl     = 1'b1;
						nxt.phase   = 2'd0;
						nxt.bit_cnt = nxt.bit_cnt + 1'b1;
					end
				end else if (nxt.phase == 2'd0) begin
					nxt.scl   = 1'b0;
					nxt.phase = 2'd1;
				end else begin
					nxt.sda     = 1'b1;
					nxt.step    = nxt.step + 1'b1;
					nxt.phase   = 2'd0;
					nxt.bit_cnt = 4'd0;
				end
			end
			i2cebm_pkg::OP_ACK: begin
				if (nxt.phase == 2'd0) begin
					nxt.scl      = 1'b1;
					nxt.wait_cnt = 16'd0;
					nxt.phase    = 2'd1;
				end else if (!sda_level || nxt.wait_cnt >= {8'd0, cfg.ack_timeout}) begin
					nxt.scl     = 1'b0;
					nxt.step    = nxt.step + 1'b1;
					nxt.phase   = 2'd0;
					nxt.bit_cnt = 4'd0;
				end else begin
					nxt.wait_cnt = nxt.wait_cnt + 1'b1;
				end
			end
			i2cebm_pkg::OP_RBYTE: begin
				if (nxt.bit_cnt == 4'd0) begin
					if (nxt.phase == 2'd0) begin
						nxt.scl   = 1'b0;
						nxt.shift = 8'd0;
						nxt.phase = 2'd1;
					end else begin
						nxt.sda     = 1'b1;
						nxt.phase   = 2'd0;
						nxt.bit_cnt = 4'd1;
					end
				end else if (nxt.phase == 2'd0) begin
					nxt.scl   = 1'b1;
					nxt.phase = 2'd1;
				end else begin
					nxt.shift = {nxt.shift[6:0], sda_level};
					nxt.scl   = 1'b0;
					nxt.phase = 2'd0;
					if (nxt.bit_cnt >= i2cebm_pkg::BITS_PER_BYTE) begin
						nxt.rx_byte = {cur.shift[6:0], sda_level};
						nxt.step    = nxt.step + 1'b1;
						nxt.bit_cnt = 4'd0;
					end else begin
						nxt.bit_cnt = nxt.bit_cnt + 1'b1;
					end
				end
			end
			i2cebm_pkg::OP_STOP: begin
				if (nxt.phase == 2'd0) begin
					nxt.sda   = 1'b0;
					nxt.phase = 2'd1;
				end else if (nxt.phase == 2'd1) begin
					nxt.scl   = 1'b1;
					nxt.phase = 2'd2;
				end else begin
					nxt.sda      = 1'b1;
					nxt.wait_cnt = nxt.is_read ? cfg.read_wait : cfg.write_wait;
					nxt.step     = nxt.step + 1'b1;
					nxt.phase    = 2'd0;
					nxt.bit_cnt  = 4'd0;
				end
			end
			i2cebm_pkg::OP_WAIT: begin
				if (nxt.wait_cnt != 16'd0) begin
					nxt.wait_cnt = nxt.wait_cnt - 1'b1;
				end else begin
					busy        = 1'b0;
					done        = 1'b1;
					nxt.step    = i2cebm_pkg::STEP_IDLE;
					nxt.phase   = 2'd0;
					nxt.bit_cnt = 4'd0;
				end
			end
			default: begin
				nxt.step = i2cebm_pkg::STEP_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire
